// ----- rtl/udpdm_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the udp port demultiplexer
// no dependencies

package udpdm_pkg;

   localparam int HEADER_BYTES = 8;
   localparam int MAX_PAYLOAD  = 2048;
   localparam int SLOT_IDX_W   = 6;   // covers up to 64 bind slots
   localparam int POS_W        = 11;
   localparam int LIMIT_W      = 12;

   // header byte offsets (big-endian fields)
   localparam logic [POS_W-1:0] HDR_SRC_HI = POS_W'(0);
   localparam logic [POS_W-1:0] HDR_SRC_LO = POS_W'(1);
   localparam logic [POS_W-1:0] HDR_DST_HI = POS_W'(2);
   localparam logic [POS_W-1:0] HDR_DST_LO = POS_W'(3);
   localparam logic [POS_W-1:0] HDR_LEN_HI = POS_W'(4);
   localparam logic [POS_W-1:0] HDR_LEN_LO = POS_W'(5);
   localparam logic [POS_W-1:0] HDR_LAST   = POS_W'(HEADER_BYTES - 1);

   localparam logic [15:0] DHCP_PORT_RESET  = 16'd68;
   localparam logic [15:0] DNS_SERVER_RESET = 16'd53;

   typedef enum logic [1:0] {
      OP_BIND     = 2'd0,
      OP_UNBIND   = 2'd1,
      OP_DATAGRAM = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ROUTE_DHCP = 2'd0,
      ROUTE_DNS  = 2'd1,
      ROUTE_SLOT = 2'd2,
      ROUTE_DROP = 2'd3
   } route_type;

   typedef enum logic [1:0] {
      SWEEP_BIND   = 2'd0,
      SWEEP_UNBIND = 2'd1,
      SWEEP_LOOKUP = 2'd2
   } sweep_kind_type;

   typedef enum logic [0:0] {
      CSR_DHCP_PORT  = 1'b0,
      CSR_DNS_SERVER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] port;
      logic [31:0] source_address;
      logic [7:0]  data_byte;
      logic        end_of_datagram;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [1:0]  route;
      logic [2:0]  slot;
      logic [31:0] sender_address;
      logic [15:0] sender_port;
      logic [7:0]  payload_byte;
      logic [10:0] payload_index;
      logic        final_byte;
   } rsp_type;

   // search token walking down the slot cells
   typedef struct packed {
      logic                  valid;
      sweep_kind_type        kind;
      logic [15:0]           key;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic                  free;
      logic [SLOT_IDX_W-1:0] free_idx;
   } sweep_token_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] idx;
      logic [15:0]           port;
   } cell_write_type;

endpackage

// ----- rtl/udpdm_cell.sv -----
`timescale 1ns / 1ps
// one bind slot: holds a port and its used flag, passes the search token on
// depends on udpdm_pkg

module udpdm_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [udpdm_pkg::SLOT_IDX_W-1:0] cell_index,
   input  udpdm_pkg::sweep_token_type       token_in,
   input  udpdm_pkg::cell_write_type        write,
   output udpdm_pkg::sweep_token_type       token_out
);
   import udpdm_pkg::*;

   logic            used_ff, used_in;
   logic [15:0]     port_ff, port_in;
   sweep_token_type pass_ff, pass_in;
   logic            match;
   logic            take_write;

   assign match      = used_ff && (port_ff == token_in.key);
   assign take_write = write.en && (write.idx == cell_index);

   always_comb begin
      pass_in = token_in;
      if (!token_in.hit && match) begin
         pass_in.hit     = 1'b1;
         pass_in.hit_idx = cell_index;
      end
      if (!token_in.free && !used_ff) begin
         pass_in.free     = 1'b1;
         pass_in.free_idx = cell_index;
      end
   end

   always_comb begin
      used_in = used_ff;
      port_in = port_ff;
      // unbind clears only the lowest matching slot
      if (token_in.valid && token_in.kind == SWEEP_UNBIND && match && !token_in.hit) begin
         used_in = 1'b0;
      end
      if (take_write) begin
         used_in = 1'b1;
         port_in = write.port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         pass_ff <= '0;
      end else begin
         used_ff <= used_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff <= port_in;
   end

   assign token_out = pass_ff;

endmodule

// ----- rtl/udp_port_demultiplexer.sv -----
`timescale 1ns / 1ps
// udp port demultiplexer: header parse, route choice and payload steering
// a datagram payload byte gives its registered result in the cycle after acceptance
// bind and unbind: status is registered from the cell row's end, busy while it searches
// the eighth header byte holds busy while the slot row is searched
// all other bytes are taken one per cycle while no search token is in the row
// synchronous reset frees every slot, clears the parser and loads ports 68 and 53

module udp_port_demultiplexer #(
   parameter int BIND_SLOTS      = 8,
   parameter int RX_BUFFER_BYTES = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  udpdm_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output udpdm_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data
);
   import udpdm_pkg::*;

   localparam logic [LIMIT_W-1:0] RX_LIMIT  = LIMIT_W'(RX_BUFFER_BYTES);
   localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_PAYLOAD);

   logic [15:0]           dhcp_port_ff, dhcp_port_in;
   logic [15:0]           dns_server_ff, dns_server_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [15:0]           hdr_source_ff, hdr_source_in;
   logic [15:0]           hdr_dest_ff, hdr_dest_in;
   logic [15:0]           len_ff, len_in;
   route_type             route_ff, route_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic                  header_done_ff, header_done_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [LIMIT_W-1:0]    plen_ff, plen_in;
   sweep_token_type       launch_ff, launch_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   sweep_token_type       chain [BIND_SLOTS+1];
   logic [BIND_SLOTS:0]   tok_valid;
   cell_write_type        wr;
   sweep_token_type       fin;
   logic                  accept;
   logic [15:0]           plen_full;
   logic [LIMIT_W-1:0]    plen_cap;
   logic [LIMIT_W-1:0]    pos_next;
   logic                  last;

   assign chain[0] = launch_ff;

   for (genvar i = 0; i < BIND_SLOTS; i++) begin : g_cell
      udpdm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_IDX_W'(i)),
         .token_in   (chain[i]),
         .write      (wr),
         .token_out  (chain[i+1])
      );
   end

   always_comb begin
      for (int k = 0; k <= BIND_SLOTS; k++) begin
         tok_valid[k] = chain[k].valid;
      end
   end

   assign busy      = |tok_valid;
   assign accept    = start && !busy;
   assign fin       = chain[BIND_SLOTS];
   assign csr_ready = 1'b1;

   assign plen_full = len_ff - 16'(HEADER_BYTES);
   assign plen_cap  = (plen_full > 16'(MAX_PAYLOAD)) ? MAX_LIMIT : plen_full[LIMIT_W-1:0];
   assign pos_next  = {1'b0, pos_ff} + LIMIT_W'(1);
   assign last      = (pos_next == limit_ff) || req_data.end_of_datagram;

   // configuration writes
   always_comb begin
      dhcp_port_in  = dhcp_port_ff;
      dns_server_in = dns_server_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DHCP_PORT:  dhcp_port_in  = csr_data;
            CSR_DNS_SERVER: dns_server_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      hdr_source_in  = hdr_source_ff;
      hdr_dest_in    = hdr_dest_ff;
      len_in         = len_ff;
      route_in       = route_ff;
      slot_in        = slot_ff;
      header_done_in = header_done_ff;
      limit_in       = limit_ff;
      plen_in        = plen_ff;
      launch_in      = '0;
      rsp_in         = '0;
      rsp_strobe_in  = 1'b0;
      wr             = '0;

      if (fin.valid) begin
         case (fin.kind)
            SWEEP_BIND: begin
               rsp_strobe_in = 1'b1;
               if (!fin.hit) begin
                  if (fin.free) begin
                     wr.en   = 1'b1;
                     wr.idx  = fin.free_idx;
                     wr.port = fin.key;
                  end else begin
                     rsp_in.status = 1'b1;
                  end
               end
            end
            SWEEP_UNBIND: begin
               rsp_strobe_in = 1'b1;
            end
            SWEEP_LOOKUP: begin
               if (fin.hit) begin
                  route_in = ROUTE_SLOT;
                  slot_in  = fin.hit_idx;
                  limit_in = (plen_ff > RX_LIMIT) ? RX_LIMIT : plen_ff;
               end else begin
                  route_in = ROUTE_DROP;
               end
            end
            default: ;
         endcase
      end else if (accept) begin
         case (opcode_type'(req_data.opcode))
            OP_BIND, OP_UNBIND: begin
               launch_in.valid = 1'b1;
               launch_in.kind  = (opcode_type'(req_data.opcode) == OP_BIND) ?
                                 SWEEP_BIND : SWEEP_UNBIND;
               launch_in.key   = req_data.port;
            end
            OP_DATAGRAM: begin
               if (!header_done_ff) begin
                  case (pos_ff)
                     HDR_SRC_HI: hdr_source_in = {req_data.data_byte, hdr_source_ff[7:0]};
                     HDR_SRC_LO: hdr_source_in = {hdr_source_ff[15:8], req_data.data_byte};
                     HDR_DST_HI: hdr_dest_in   = {req_data.data_byte, hdr_dest_ff[7:0]};
                     HDR_DST_LO: hdr_dest_in   = {hdr_dest_ff[15:8], req_data.data_byte};
                     HDR_LEN_HI: len_in        = {req_data.data_byte, len_ff[7:0]};
                     HDR_LEN_LO: len_in        = {len_ff[15:8], req_data.data_byte};
                     default: ;
                  endcase
                  if (pos_ff >= HDR_LAST) begin
                     header_done_in = 1'b1;
                     pos_in         = '0;
                     limit_in       = '0;
                     route_in       = ROUTE_DROP;
                     if (len_ff > 16'(HEADER_BYTES)) begin
                        if (hdr_dest_ff == dhcp_port_ff) begin
                           route_in = ROUTE_DHCP;
                           limit_in = plen_cap;
                        end else if (hdr_source_ff == dns_server_ff) begin
                           route_in = ROUTE_DNS;
                           limit_in = plen_cap;
                        end else if (!req_data.end_of_datagram) begin
                           // slot match needs a walk down the cell row
                           plen_in         = plen_cap;
                           launch_in.valid = 1'b1;
                           launch_in.kind  = SWEEP_LOOKUP;
                           launch_in.key   = hdr_dest_ff;
                        end
                     end
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end else if (route_ff != ROUTE_DROP && {1'b0, pos_ff} < limit_ff) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_in.kind           = 1'b1;
                  rsp_in.route          = route_ff;
                  rsp_in.slot           = (route_ff == ROUTE_SLOT) ? slot_ff[2:0] : 3'd0;
                  rsp_in.sender_address = req_data.source_address;
                  rsp_in.sender_port    = hdr_source_ff;
                  rsp_in.payload_byte   = req_data.data_byte;
                  rsp_in.payload_index  = pos_ff;
                  rsp_in.final_byte     = last;
                  if (last) begin
                     route_in = ROUTE_DROP;
                  end else begin
                     pos_in = pos_next[POS_W-1:0];
                  end
               end
               if (req_data.end_of_datagram) begin
                  pos_in         = '0;
                  header_done_in = 1'b0;
                  route_in       = ROUTE_DROP;
                  limit_in       = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dhcp_port_ff   <= DHCP_PORT_RESET;
         dns_server_ff  <= DNS_SERVER_RESET;
         pos_ff         <= '0;
         hdr_source_ff  <= '0;
         hdr_dest_ff    <= '0;
         len_ff         <= '0;
         route_ff       <= ROUTE_DROP;
         slot_ff        <= '0;
         header_done_ff <= 1'b0;
         limit_ff       <= '0;
         plen_ff        <= '0;
         launch_ff      <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         dhcp_port_ff   <= dhcp_port_in;
         dns_server_ff  <= dns_server_in;
         pos_ff         <= pos_in;
         hdr_source_ff  <= hdr_source_in;
         hdr_dest_ff    <= hdr_dest_in;
         len_ff         <= len_in;
         route_ff       <= route_in;
         slot_ff        <= slot_in;
         header_done_ff <= header_done_in;
         limit_ff       <= limit_in;
         plen_ff        <= plen_in;
         launch_ff      <= launch_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // only one search token is ever in the cell row
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one search token in flight");

   // a finished bind or unbind search always reports its status next cycle
   a_status_follows: assert property (@(posedge clock) disable iff (reset)
      fin.valid && (fin.kind == SWEEP_BIND || fin.kind == SWEEP_UNBIND)
      |=> rsp_strobe && !rsp_data.kind)
      else $error("bind or unbind search ended without a status transaction");

   // payload is only ever steered to a live route
   a_payload_route: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind |-> rsp_data.route != ROUTE_DROP)
      else $error("payload transaction on a dropped route");

   // a route lookup completes before any further byte can be taken
   a_lookup_blocks: assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> !accept)
      else $error("transaction accepted while a search finishes");
`endif

endmodule
